### src/hijri_month_from_gregorian_macros.svh
// Assertion helpers for the Hijri month converter.
`ifndef HIJRI_MONTH_FROM_GREGORIAN_MACROS_SVH
`define HIJRI_MONTH_FROM_GREGORIAN_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HMG_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication after a fixed number of clock edges.
`define HMG_ASSERT_DELAY(lbl, clk, rst, ante, dly, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
      else $error(msg);

`endif

### src/hmg_pkg.sv
package hmg_pkg;

   typedef logic [13:0]        year_type;
   typedef logic [3:0]         month_type;
   typedef logic [4:0]         mday_type;
   typedef logic signed [23:0] daynum_type;
   typedef logic signed [14:0] hyear_type;

   localparam int YEAR_MAX = 9999;

   // accepting edge to the edge that takes the result
   localparam int PIPE_DEPTH = 8;

   localparam month_type MONTH_JAN = 4'd1;
   localparam month_type MONTH_FEB = 4'd2;
   localparam month_type MONTH_DEC = 4'd12;

   // day numbers are Julian day minus one half
   localparam int GREG_DAY0  = 1721424;
   localparam int ISL_DAY0   = 1948439;
   localparam int EPOCH_GAP  = GREG_DAY0 - ISL_DAY0;
   localparam int SHIFT_DAYS = 10;
   localparam int GREG_YEAR_DAYS = 365;

   // floor(x / 100) for x below 2^14
   localparam int DIV100_SHIFT = 19;
   localparam int CENTURY      = 100;
   localparam logic [12:0] DIV100_RECIP =
      13'(((1 << DIV100_SHIFT) + CENTURY - 1) / CENTURY);

   // Hijri year: floor((30 D + 10646) / 10631), numerator biased positive
   localparam int HY_DIV        = 10631;
   localparam int HY_BIAS       = 640;
   localparam int HY_NUM_OFFSET = 10646 + HY_BIAS * HY_DIV;
   localparam int HY_SHIFT      = 41;
   localparam logic [27:0] HY_RECIP =
      28'(((64'd1 << HY_SHIFT) + 64'(HY_DIV) - 64'd1) / 64'(HY_DIV));

   // leap days before the year: floor((3 + 11 hy) / 30), biased positive
   localparam int FY_DIV        = 30;
   localparam int FY_YEAR_MUL   = 11;
   localparam int FY_BIAS       = 235;
   localparam int FY_NUM_OFFSET = 3 - FY_YEAR_MUL * HY_BIAS + FY_DIV * FY_BIAS;
   localparam int FY_SHIFT      = 22;
   localparam logic [17:0] FY_RECIP =
      18'(((1 << FY_SHIFT) + FY_DIV - 1) / FY_DIV);

   // day offset within the Hijri year, counted from its first day
   localparam int HIJRI_YEAR_DAYS = 354;
   localparam int EP_OFFSET = HIJRI_YEAR_DAYS * (HY_BIAS + 1) + FY_BIAS;

   // month = floor(2 ep / 59) + 1, capped at twelve
   localparam int HM_DIV    = 59;
   localparam int HM_SHIFT  = 16;
   localparam int HM_MONTHS = 12;
   localparam logic [10:0] HM_RECIP = 11'(((1 << HM_SHIFT) + HM_DIV - 1) / HM_DIV);
   localparam int HM_CAP_EP = ((HM_MONTHS - 1) * HM_DIV + 1) / 2;

   function automatic mday_type month_days(input month_type m);
      mday_type r;
      case (m)
         4'd1:    r = 5'd31;
         4'd2:    r = 5'd28;
         4'd3:    r = 5'd31;
         4'd4:    r = 5'd30;
         4'd5:    r = 5'd31;
         4'd6:    r = 5'd30;
         4'd7:    r = 5'd31;
         4'd8:    r = 5'd31;
         4'd9:    r = 5'd30;
         4'd10:   r = 5'd31;
         4'd11:   r = 5'd30;
         4'd12:   r = 5'd31;
         default: r = 5'd0;
      endcase
      return r;
   endfunction

   // floor((367 m - 362) / 12)
   function automatic logic [8:0] month_start(input month_type m);
      logic [8:0] r;
      case (m)
         4'd1:    r = 9'd0;
         4'd2:    r = 9'd31;
         4'd3:    r = 9'd61;
         4'd4:    r = 9'd92;
         4'd5:    r = 9'd122;
         4'd6:    r = 9'd153;
         4'd7:    r = 9'd183;
         4'd8:    r = 9'd214;
         4'd9:    r = 9'd245;
         4'd10:   r = 9'd275;
         4'd11:   r = 9'd306;
         4'd12:   r = 9'd336;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

endpackage

### src/hijri_month_from_gregorian.sv
// Gregorian date to tabular Islamic year and month for a crescent event.
// Fully pipelined: one item is taken on every clock (busy is never high)
// and its result shows on the rsp_ ports for a single cycle, with
// rsp_strobe high, once it has passed every register stage. The receiver
// cannot stall, so results must be captured when the strobe is seen.
// Depth is set by the chain of constant divides (by 100, 10631, 30, 59),
// each done as a reciprocal multiply with its own register stage.
// Invalid dates (year outside 1..9999, bad month or day) and a month
// result below 1 give rsp_valid_res low with year and month zero.
// The block holds no state between items.
`include "hijri_month_from_gregorian_macros.svh"

module hijri_month_from_gregorian (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  hmg_pkg::year_type    req_greg_year,
   input  hmg_pkg::month_type   req_greg_month,
   input  hmg_pkg::mday_type    req_greg_day,
   input  logic                 req_is_morning,
   output logic                 rsp_strobe,
   output logic                 rsp_valid_res,
   output hmg_pkg::hyear_type   rsp_hijri_year,
   output hmg_pkg::month_type   rsp_hijri_month
);

   // ---------------- stage 0: input register ----------------
   logic                v0_ff, v0_in;
   hmg_pkg::year_type   y0_ff;
   hmg_pkg::month_type  m0_ff;
   hmg_pkg::mday_type   d0_ff;
   logic                morn0_ff;

   assign busy  = 1'b0;
   assign v0_in = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= v0_in;
      end
      if (v0_in) begin
         y0_ff    <= req_greg_year;
         m0_ff    <= req_greg_month;
         d0_ff    <= req_greg_day;
         morn0_ff <= req_is_morning;
      end
   end

   // ---------------- stage 1: centuries and year days ----------------
   logic                v1_ff;
   hmg_pkg::year_type   y1_ff, py_s1;
   hmg_pkg::month_type  m1_ff;
   hmg_pkg::mday_type   d1_ff;
   logic                morn1_ff;
   logic [26:0]         qy_prod, qp_prod;
   logic [7:0]          qy1_ff, qy1_in, qp1_ff, qp1_in;
   logic [23:0]         base1_ff, base1_in;

   always_comb begin
      py_s1    = y0_ff - 14'd1;
      qy_prod  = 27'(y0_ff) * 27'(hmg_pkg::DIV100_RECIP);
      qp_prod  = 27'(py_s1) * 27'(hmg_pkg::DIV100_RECIP);
      qy1_in   = qy_prod[hmg_pkg::DIV100_SHIFT +: 8];
      qp1_in   = qp_prod[hmg_pkg::DIV100_SHIFT +: 8];
      // 365 (y-1) + floor((y-1)/4)
      base1_in = 24'(py_s1) * 24'(hmg_pkg::GREG_YEAR_DAYS) + 24'(py_s1 >> 2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v0_ff;
      end
      y1_ff    <= y0_ff;
      m1_ff    <= m0_ff;
      d1_ff    <= d0_ff;
      morn1_ff <= morn0_ff;
      qy1_ff   <= qy1_in;
      qp1_ff   <= qp1_in;
      base1_ff <= base1_in;
   end

   // ---------------- stage 2: date check and day number ----------------
   logic                  v2_ff, ok2_ff, ok2_in;
   hmg_pkg::daynum_type   day2_ff, day2_in;
   logic [6:0]            r100;
   logic                  leap;
   hmg_pkg::mday_type     maxd;
   hmg_pkg::daynum_type   adj, shift;

   function automatic hmg_pkg::daynum_type req_shift(input logic morning);
      hmg_pkg::daynum_type r;
      if (morning) begin
         r = 24'(hmg_pkg::EPOCH_GAP - hmg_pkg::SHIFT_DAYS);
      end else begin
         r = 24'(hmg_pkg::EPOCH_GAP + hmg_pkg::SHIFT_DAYS);
      end
      return r;
   endfunction

   always_comb begin
      r100 = 7'(y1_ff - 14'(qy1_ff) * 14'(hmg_pkg::CENTURY));
      // divisible by 400 when the century count is a multiple of four
      leap = (y1_ff[1:0] == 2'd0) && ((r100 != 7'd0) || (qy1_ff[1:0] == 2'd0));
      maxd = hmg_pkg::month_days(m1_ff)
             + 5'((m1_ff == hmg_pkg::MONTH_FEB) && leap);
      ok2_in = (y1_ff != 14'd0) && (int'(y1_ff) <= hmg_pkg::YEAR_MAX)
               && (m1_ff >= hmg_pkg::MONTH_JAN) && (m1_ff <= hmg_pkg::MONTH_DEC)
               && (d1_ff != 5'd0) && (d1_ff <= maxd);

      // March onward: February was counted as 30 days by the month table
      if (m1_ff > hmg_pkg::MONTH_FEB) begin
         adj = leap ? -24'sd1 : -24'sd2;
      end else begin
         adj = '0;
      end
      shift = req_shift(morn1_ff);

      // D = day number minus the Hijri epoch, event shift included
      day2_in = $signed(base1_ff) - $signed(24'(qp1_ff)) + $signed(24'(qp1_ff >> 2))
                + $signed(24'(hmg_pkg::month_start(m1_ff))) + adj
                + $signed(24'(d1_ff)) + shift;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      ok2_ff  <= ok2_in;
      day2_ff <= day2_in;
   end

   // ---------------- stage 3: Hijri year numerator ----------------
   logic                  v3_ff, ok3_ff;
   hmg_pkg::daynum_type   day3_ff;
   logic signed [31:0]    n_full;
   logic [26:0]           num3_ff, num3_in;

   always_comb begin
      n_full  = (32'(day2_ff) <<< 5) - (32'(day2_ff) <<< 1)
                + 32'(hmg_pkg::HY_NUM_OFFSET);
      num3_in = n_full[26:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      ok3_ff  <= ok2_ff;
      day3_ff <= day2_ff;
      num3_ff <= num3_in;
   end

   // ---------------- stage 4: divide by 10631 ----------------
   logic                  v4_ff, ok4_ff;
   hmg_pkg::daynum_type   day4_ff;
   logic [54:0]           hy_prod;
   logic [13:0]           q4_ff, q4_in;   // Hijri year plus bias

   always_comb begin
      hy_prod = 55'(num3_ff) * 55'(hmg_pkg::HY_RECIP);
      q4_in   = hy_prod[hmg_pkg::HY_SHIFT +: 14];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
      ok4_ff  <= ok3_ff;
      day4_ff <= day3_ff;
      q4_ff   <= q4_in;
   end

   // ---------------- stage 5: year start pieces ----------------
   logic                  v5_ff, ok5_ff;
   logic [13:0]           q5_ff;
   logic [16:0]           fnum5_ff, fnum5_in;
   hmg_pkg::daynum_type   epb5_ff, epb5_in;

   always_comb begin
      fnum5_in = 17'(q4_ff) * 17'(hmg_pkg::FY_YEAR_MUL) + 17'(hmg_pkg::FY_NUM_OFFSET);
      epb5_in  = day4_ff - $signed(24'(q4_ff) * 24'(hmg_pkg::HIJRI_YEAR_DAYS))
                 + 24'(hmg_pkg::EP_OFFSET);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= v4_ff;
      end
      ok5_ff   <= ok4_ff;
      q5_ff    <= q4_ff;
      fnum5_ff <= fnum5_in;
      epb5_ff  <= epb5_in;
   end

   // ---------------- stage 6: divide by 30 ----------------
   logic                  v6_ff, ok6_ff;
   logic [13:0]           q6_ff;
   hmg_pkg::daynum_type   epb6_ff;
   logic [34:0]           fy_prod;
   logic [12:0]           f6_ff, f6_in;

   always_comb begin
      fy_prod = 35'(fnum5_ff) * 35'(hmg_pkg::FY_RECIP);
      f6_in   = fy_prod[hmg_pkg::FY_SHIFT +: 13];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else begin
         v6_ff <= v5_ff;
      end
      ok6_ff  <= ok5_ff;
      q6_ff   <= q5_ff;
      epb6_ff <= epb5_ff;
      f6_ff   <= f6_in;
   end

   // ---------------- stage 7: month and result register ----------------
   hmg_pkg::daynum_type   ep;
   logic [20:0]           hm_prod;
   logic [4:0]            hm_quot;
   hmg_pkg::month_type    hm;
   logic                  ok_out;
   logic                  rsp_strobe_ff, rsp_valid_res_ff, rsp_valid_res_in;
   hmg_pkg::hyear_type    rsp_hijri_year_ff, rsp_hijri_year_in;
   hmg_pkg::month_type    rsp_hijri_month_ff, rsp_hijri_month_in;

   always_comb begin
      ep      = epb6_ff - $signed(24'(f6_ff));
      hm_prod = 21'({ep[8:0], 1'b0}) * 21'(hmg_pkg::HM_RECIP);
      hm_quot = hm_prod[hmg_pkg::HM_SHIFT +: 5];
      if (ep >= 24'(hmg_pkg::HM_CAP_EP)) begin
         hm = 4'(hmg_pkg::HM_MONTHS);
      end else begin
         hm = 4'(hm_quot) + 4'd1;
      end
      // negative offset: month would come out below one
      ok_out             = ok6_ff && !ep[23];
      rsp_valid_res_in   = v6_ff && ok_out;
      rsp_hijri_year_in  = ok_out ? (15'(q6_ff) - 15'(hmg_pkg::HY_BIAS)) : '0;
      rsp_hijri_month_in = ok_out ? hm : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff    <= 1'b0;
         rsp_valid_res_ff <= 1'b0;
      end else begin
         rsp_strobe_ff    <= v6_ff;
         rsp_valid_res_ff <= rsp_valid_res_in;
      end
      rsp_hijri_year_ff  <= rsp_hijri_year_in;
      rsp_hijri_month_ff <= rsp_hijri_month_in;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_valid_res   = rsp_valid_res_ff;
   assign rsp_hijri_year  = rsp_hijri_year_ff;
   assign rsp_hijri_month = rsp_hijri_month_ff;

   // ---------------- assertions ----------------
   `HMG_ASSERT_DELAY(a_item_latency, clock, reset, start && !busy,
      (hmg_pkg::PIPE_DEPTH), rsp_strobe, "accepted item produced no result")
   `HMG_ASSERT_IMPL(a_no_spurious, clock, reset, rsp_strobe,
      $past(start && !busy, hmg_pkg::PIPE_DEPTH), "result without an accepted item")
   `HMG_ASSERT_IMPL(a_invalid_zero, clock, reset, rsp_strobe && !rsp_valid_res,
      (rsp_hijri_year == '0) && (rsp_hijri_month == '0), "invalid result carries data")
   `HMG_ASSERT_IMPL(a_month_range, clock, reset, rsp_valid_res,
      rsp_strobe && (rsp_hijri_month >= hmg_pkg::MONTH_JAN)
      && (rsp_hijri_month <= hmg_pkg::MONTH_DEC), "valid result with bad month")

endmodule

### tb/hijri_month_from_gregorian_tb.sv
`timescale 1ns / 100ps

// Self-checking bench for the Gregorian to tabular Hijri month converter.
// Items go in on start/busy, and results come back on rsp_strobe, one per item.
// The bench predicts every result, or takes a typed row's answer, and compares it,
// field by field, with the oldest prediction still waiting.
module hijri_month_from_gregorian_tb;

   // day numbers are Julian day minus one half
   localparam longint GREG_ORIGIN = 1721424;
   localparam longint HIJRI_ORIGIN = 1948439;
   localparam longint CRESCENT_SHIFT = 10;
   localparam int LAST_YEAR = 9999;
   localparam int ITEMS_PER_PHASE = 484;
   localparam int TAIL_CYCLES = 16;       // pipeline is eight stages, leave margin
   localparam int LIMIT_CYCLES = 200000;
   localparam int NUM_ROWS = 22;

   typedef struct packed {
      logic                ok;
      hmg_pkg::hyear_type  year;
      hmg_pkg::month_type  month;
   } crescent_month_type;

   // directed row: date, event kind, and an optional hand-typed answer
   typedef struct packed {
      hmg_pkg::year_type   y;
      hmg_pkg::month_type  m;
      hmg_pkg::mday_type   d;
      logic                morn;
      logic                typed;
      crescent_month_type  want;
   } date_row_type;

   localparam crescent_month_type NO_MONTH = '{ok: 1'b0, year: '0, month: '0};

   // typed rows are the invalid dates: the answer is always all zero
   localparam date_row_type DATE_TABLE [NUM_ROWS] = '{
      '{14'd0,     4'd1,  5'd1,  1'b0, 1'b1, NO_MONTH},   // year zero
      '{14'd10000, 4'd6,  5'd15, 1'b1, 1'b1, NO_MONTH},   // year just past range
      '{14'h3FFF,  4'd12, 5'd31, 1'b0, 1'b1, NO_MONTH},   // all-ones year
      '{14'd2000,  4'd0,  5'd10, 1'b1, 1'b1, NO_MONTH},   // month zero
      '{14'd2000,  4'd13, 5'd10, 1'b0, 1'b1, NO_MONTH},   // month 13
      '{14'd2000,  4'hF,  5'h1F, 1'b1, 1'b1, NO_MONTH},   // month 15, day 31
      '{14'd1999,  4'd3,  5'd0,  1'b0, 1'b1, NO_MONTH},   // day zero
      '{14'd1900,  4'd2,  5'd29, 1'b1, 1'b1, NO_MONTH},   // century, not leap
      '{14'd2000,  4'd2,  5'd30, 1'b0, 1'b1, NO_MONTH},   // Feb 30 in leap year
      '{14'd2023,  4'd4,  5'd31, 1'b1, 1'b1, NO_MONTH},   // April 31
      '{14'd2023,  4'd2,  5'd29, 1'b0, 1'b1, NO_MONTH},   // Feb 29, plain year
      '{14'd1,     4'd1,  5'd1,  1'b1, 1'b0, NO_MONTH},   // first day, morning
      '{14'd1,     4'd1,  5'd1,  1'b0, 1'b0, NO_MONTH},   // first day, evening
      '{14'd9999,  4'd12, 5'd31, 1'b1, 1'b0, NO_MONTH},   // last day, morning
      '{14'd9999,  4'd12, 5'd31, 1'b0, 1'b0, NO_MONTH},   // last day, evening
      '{14'd2000,  4'd2,  5'd29, 1'b1, 1'b0, NO_MONTH},   // 400-year leap day
      '{14'd2024,  4'd2,  5'd29, 1'b0, 1'b0, NO_MONTH},   // plain leap day
      '{14'd622,   4'd7,  5'd16, 1'b0, 1'b0, NO_MONTH},   // near Hijri epoch
      '{14'd622,   4'd7,  5'd16, 1'b1, 1'b0, NO_MONTH},   // before epoch
      '{14'd400,   4'd3,  5'd1,  1'b1, 1'b0, NO_MONTH},   // negative Hijri year
      '{14'd2024,  4'd7,  5'd7,  1'b0, 1'b0, NO_MONTH},   // around a Hijri new year
      '{14'd8191,  4'd11, 5'd30, 1'b1, 1'b0, NO_MONTH}    // year bits 0..12 set
   };

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   hmg_pkg::year_type   req_greg_year;
   hmg_pkg::month_type  req_greg_month;
   hmg_pkg::mday_type   req_greg_day;
   logic                req_is_morning;
   logic                rsp_strobe;
   logic                rsp_valid_res;
   hmg_pkg::hyear_type  rsp_hijri_year;
   hmg_pkg::month_type  rsp_hijri_month;

   // driven with the item so the monitor knows what answer goes with it
   logic                hint_typed;
   crescent_month_type  hint_month;

   logic                date_taken = 1'b0;   // item went in at the last rising edge
   crescent_month_type  due_months[$];       // predictions, oldest first
   int unsigned         mismatches = 0;
   int unsigned         cycle_count = 0;

   hijri_month_from_gregorian dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_greg_year   (req_greg_year),
      .req_greg_month  (req_greg_month),
      .req_greg_day    (req_greg_day),
      .req_is_morning  (req_is_morning),
      .rsp_strobe      (rsp_strobe),
      .rsp_valid_res   (rsp_valid_res),
      .rsp_hijri_year  (rsp_hijri_year),
      .rsp_hijri_month (rsp_hijri_month)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   function automatic longint floor_quot(input longint num, input longint den);
      longint q;
      q = num / den;
      if ((num % den) != 0 && num < 0)
         q = q - 1;
      return q;
   endfunction

   function automatic bit greg_leap(input longint y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   function automatic int greg_month_len(input longint y, input longint m);
      int lens [12];
      lens = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      return lens[m - 1] + ((m == 2 && greg_leap(y)) ? 1 : 0);
   endfunction

   // Hijri year and month holding the date moved by the crescent shift
   function automatic crescent_month_type crescent_month(input hmg_pkg::year_type y,
                                                         input hmg_pkg::month_type m,
                                                         input hmg_pkg::mday_type d,
                                                         input logic morn);
      longint yy, mm, dd, py, dn, hy, leapdays, ofs, hm;
      crescent_month_type r;
      r = NO_MONTH;
      yy = longint'(y);
      mm = longint'(m);
      dd = longint'(d);
      if (yy < 1 || yy > LAST_YEAR || mm < 1 || mm > 12 || dd < 1)
         return r;
      if (dd > greg_month_len(yy, mm))
         return r;
      py = yy - 1;
      dn = GREG_ORIGIN + 365 * py + py / 4 - py / 100 + py / 400
           + (367 * mm - 362) / 12 + dd;
      if (mm > 2)
         dn = dn - (greg_leap(yy) ? 1 : 2);
      dn = morn ? dn - CRESCENT_SHIFT : dn + CRESCENT_SHIFT;
      hy = floor_quot(30 * (dn - HIJRI_ORIGIN) + 10646, 10631);
      leapdays = floor_quot(3 + 11 * hy, 30);
      ofs = dn - 30 - (hy - 1) * 354 - leapdays - (HIJRI_ORIGIN - 1);
      hm = 1 - floor_quot(-2 * ofs, 59);
      if (hm > 12)
         hm = 12;
      if (hm < 1)
         return r;
      r.ok = 1'b1;
      r.year = hmg_pkg::hyear_type'(hy);
      r.month = hmg_pkg::month_type'(hm);
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Monitor: record accepted items, check every strobed result
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      crescent_month_type want;
      crescent_month_type pred;
      date_taken <= !reset && start && !busy;
      if (!reset && start && !busy) begin
         pred = hint_typed ? hint_month :
                crescent_month(req_greg_year, req_greg_month, req_greg_day, req_is_morning);
         due_months = {due_months, pred};
      end
      if (!reset && rsp_strobe) begin
         if (due_months.size() == 0) begin
            mismatches <= mismatches + 1;
            $display("%0t: result with nothing pending: valid %0b year %0d month %0d",
                     $time, rsp_valid_res, rsp_hijri_year, rsp_hijri_month);
         end else begin
            want = due_months.pop_front();
            if (rsp_valid_res !== want.ok || rsp_hijri_year !== want.year ||
                rsp_hijri_month !== want.month)
               mismatches <= mismatches + 1;
            if (rsp_valid_res !== want.ok)
               $display("%0t: valid_res expected %0b, actual %0b",
                        $time, want.ok, rsp_valid_res);
            if (rsp_hijri_year !== want.year)
               $display("%0t: hijri_year expected %0d, actual %0d",
                        $time, want.year, rsp_hijri_year);
            if (rsp_hijri_month !== want.month)
               $display("%0t: hijri_month expected %0d, actual %0d",
                        $time, want.month, rsp_hijri_month);
         end
      end
   end

   // watchdog on the whole run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Driver: everything changes on the falling edge
   // ---------------------------------------------------------------------

   // hold the item until an edge takes it; returns on the following falling edge
   task automatic issue_date(input hmg_pkg::year_type y, input hmg_pkg::month_type m,
                             input hmg_pkg::mday_type d, input logic morn,
                             input logic typed, input crescent_month_type want);
      req_greg_year  <= y;
      req_greg_month <= m;
      req_greg_day   <= d;
      req_is_morning <= morn;
      hint_typed     <= typed;
      hint_month     <= want;
      start          <= 1'b1;
      do
         @(negedge clock);
      while (!date_taken);
   endtask

   // sender holds off until every pending result is back
   task automatic drain_results;
      start <= 1'b0;
      while (due_months.size() != 0)
         @(negedge clock);
   endtask

   // mostly well-formed dates, some broken days/years, some raw noise
   task automatic issue_random_date;
      hmg_pkg::year_type  y;
      hmg_pkg::month_type m;
      hmg_pkg::mday_type  d;
      int                 pick;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         // raw noise over every bit of every field
         y = hmg_pkg::year_type'($urandom_range(0, 16383));
         m = hmg_pkg::month_type'($urandom_range(0, 15));
         d = hmg_pkg::mday_type'($urandom_range(0, 31));
      end else begin
         if (pick < 60)
            y = hmg_pkg::year_type'($urandom_range(1, LAST_YEAR));
         else if (pick < 70)
            y = hmg_pkg::year_type'($urandom_range(1, 40));
         else if (pick < 80)
            y = hmg_pkg::year_type'($urandom_range(LAST_YEAR - 40, LAST_YEAR));
         else
            y = hmg_pkg::year_type'($urandom_range(1400, 2200));
         m = hmg_pkg::month_type'($urandom_range(1, 12));
         d = hmg_pkg::mday_type'($urandom_range(1, greg_month_len(y, m)));
         if (pick >= 90) begin
            // broken date: day past month end, day zero, or year out of range
            case ($urandom_range(0, 2))
               0: d = hmg_pkg::mday_type'($urandom_range(greg_month_len(y, m) + 1,
                                                         31 + 1) % 32);
               1: d = '0;
               default: y = ($urandom_range(0, 1) != 0) ? hmg_pkg::year_type'(0) :
                            hmg_pkg::year_type'($urandom_range(LAST_YEAR + 1, 16383));
            endcase
         end
      end
      issue_date(y, m, d, 1'($urandom_range(0, 1)), 1'b0, NO_MONTH);
   endtask

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------

   initial begin
      int idle_pct [3];
      idle_pct = '{13, 85, 0};
      reset = 1'b1;
      start = 1'b0;
      req_greg_year = '0;
      req_greg_month = '0;
      req_greg_day = '0;
      req_is_morning = 1'b0;
      hint_typed = 1'b0;
      hint_month = NO_MONTH;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed rows back to back
      foreach (DATE_TABLE[i])
         issue_date(DATE_TABLE[i].y, DATE_TABLE[i].m, DATE_TABLE[i].d, DATE_TABLE[i].morn,
                    DATE_TABLE[i].typed, DATE_TABLE[i].want);
      drain_results();

      // random items: light idling, heavy idling, then full rate;
      // the sender empties the pipe between phases
      for (int ph = 0; ph < 3; ph++) begin
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            while ($urandom_range(0, 99) < idle_pct[ph]) begin
               start <= 1'b0;
               @(negedge clock);
            end
            issue_random_date();
         end
         drain_results();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && due_months.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
